// File: rtl/core/ghbpf_pkg.sv
// ----------------------------------------------------------------------------
// ghbpf_pkg
// Constants, types and helpers shared by the history buffer prefetcher files.
// ----------------------------------------------------------------------------
package ghbpf_pkg;

    // Both depths are powers of two.
    localparam int HIST_DEPTH        = 256;
    localparam int INDEX_DEPTH       = 256;
    localparam int BLOCK_OFFSET_BITS = 6;

    localparam int ADDR_W      = 64;
    localparam int IP_W        = 64;
    localparam int PF_W        = 58;
    localparam int BLK_W       = ADDR_W - BLOCK_OFFSET_BITS;
    localparam int HIST_PTR_W  = $clog2(HIST_DEPTH);
    localparam int INDEX_PTR_W = $clog2(INDEX_DEPTH);

    typedef struct packed {
        logic [BLK_W-1:0]      block;
        logic [IP_W-1:0]       instr;
        logic                  link_ok;
        logic [HIST_PTR_W-1:0] link;
    } hist_entry_t;

    typedef struct packed {
        logic [IP_W-1:0]       tag;
        logic [HIST_PTR_W-1:0] ptr;
    } index_entry_t;

    localparam int HIST_ENTRY_W  = $bits(hist_entry_t);
    localparam int INDEX_ENTRY_W = $bits(index_entry_t);

    function automatic logic [PF_W-1:0] to_pf(input logic [BLK_W-1:0] b);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(b);
        return w[PF_W-1:0];
    endfunction

endpackage

// File: rtl/core/ghb_pc_stride_prefetcher.sv
// ----------------------------------------------------------------------------
// ghb_pc_stride_prefetcher
// Global history buffer prefetcher that detects a constant stride per
// instruction address and issues two prefetch blocks.
// ----------------------------------------------------------------------------
// A hit item is taken and the block is ready again at once. A miss holds the
// block for the index update when the instruction has no usable history,
// also for one or both link states when a link is followed, and for both
// plus the two result items when a stride is found; each result waits for
// out_ready. This follows the chain of dependent reads: the index slot, then
// via the single history RAM read port the newer and older linked entries.
// No new item is taken until the previous one is finished, so no two
// accesses to the same entry ever overlap. Results come from registers.
module ghb_pc_stride_prefetcher (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ghbpf_pkg::ADDR_W-1:0] access_address,
    input  logic [ghbpf_pkg::IP_W-1:0]   instr_address,
    input  logic                       was_hit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ghbpf_pkg::PF_W-1:0]   prefetch_block,
    output logic                       last_of_run
);

    import ghbpf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INDEX,
        S_LINK1,
        S_LINK2,
        S_OUT1,
        S_OUT2
    } state_t;

    state_t                 state_reg, state_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [IP_W-1:0]        ip_reg, ip_next;
    logic [INDEX_PTR_W-1:0] slot_reg, slot_next;
    logic                   vld_reg, vld_next;
    logic [HIST_PTR_W-1:0]  head_reg, head_next;
    logic [BLK_W-1:0]       s1_reg, s1_next;
    logic [BLK_W-1:0]       pblk_reg, pblk_next;
    logic [BLK_W-1:0]       pf2_reg, pf2_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PF_W-1:0]        pf_reg, pf_next;
    logic                   last_reg, last_next;
    logic [INDEX_DEPTH-1:0] idx_valid_reg, idx_valid_next;

    logic                   idx_we;
    logic [INDEX_PTR_W-1:0] idx_raddr;
    index_entry_t           idx_wdata, idx_rdata;
    logic                   hist_we;
    logic [HIST_PTR_W-1:0]  hist_raddr;
    hist_entry_t            hist_wdata, hist_rdata;

    logic                   has_prev;
    logic [BLK_W-1:0]       s2;
    logic [INDEX_PTR_W-1:0] in_slot;

    ghbpf_ram #(
        .WIDTH (INDEX_ENTRY_W),
        .DEPTH (INDEX_DEPTH)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (slot_reg),
        .wdata (idx_wdata),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    ghbpf_ram #(
        .WIDTH (HIST_ENTRY_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (head_reg),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign prefetch_block = pf_reg;
    assign last_of_run    = last_reg;

    assign in_slot  = instr_address[INDEX_PTR_W-1:0];
    assign has_prev = vld_reg && (idx_rdata.tag == ip_reg);
    assign s2       = pblk_reg - hist_rdata.block;

    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        ip_next        = ip_reg;
        slot_next      = slot_reg;
        vld_next       = vld_reg;
        head_next      = head_reg;
        s1_next        = s1_reg;
        pblk_next      = pblk_reg;
        pf2_next       = pf2_reg;
        out_valid_next = out_valid_reg;
        pf_next        = pf_reg;
        last_next      = last_reg;
        idx_valid_next = idx_valid_reg;

        idx_we             = 1'b0;
        idx_raddr          = in_slot;
        idx_wdata.tag      = ip_reg;
        idx_wdata.ptr      = head_reg;
        hist_we            = 1'b0;
        hist_raddr         = idx_rdata.ptr;
        hist_wdata.block   = blk_reg;
        hist_wdata.instr   = ip_reg;
        hist_wdata.link_ok = has_prev;
        hist_wdata.link    = has_prev ? idx_rdata.ptr : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !was_hit)
                begin
                    blk_next   = access_address[ADDR_W-1:BLOCK_OFFSET_BITS];
                    ip_next    = instr_address;
                    slot_next  = in_slot;
                    vld_next   = idx_valid_reg[in_slot];
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                idx_we                   = 1'b1;
                hist_we                  = 1'b1;
                idx_valid_next[slot_reg] = 1'b1;
                head_next = (head_reg == HIST_PTR_W'(HIST_DEPTH - 1)) ?
                            '0 : head_reg + 1'b1;
                // A link back to the slot being written gives zero strides.
                if (has_prev && (idx_rdata.ptr != head_reg))
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LINK1:
            begin
                hist_raddr = hist_rdata.link;
                if ((hist_rdata.instr == ip_reg) && hist_rdata.link_ok)
                begin
                    s1_next    = blk_reg - hist_rdata.block;
                    pblk_next  = hist_rdata.block;
                    state_next = S_LINK2;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LINK2:
            begin
                if ((hist_rdata.instr == ip_reg) && (s2 == s1_reg) && (s1_reg != '0))
                begin
                    out_valid_next = 1'b1;
                    pf_next        = to_pf(blk_reg + s1_reg);
                    last_next      = 1'b0;
                    pf2_next       = blk_reg + {s1_reg[BLK_W-2:0], 1'b0};
                    state_next     = S_OUT1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT1:
            begin
                if (out_ready)
                begin
                    pf_next    = to_pf(pf2_reg);
                    last_next  = 1'b1;
                    state_next = S_OUT2;
                end
            end
            S_OUT2:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            idx_valid_reg <= idx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        ip_reg   <= ip_next;
        slot_reg <= slot_next;
        vld_reg  <= vld_next;
        s1_reg   <= s1_next;
        pblk_reg <= pblk_next;
        pf2_reg  <= pf2_next;
        pf_reg   <= pf_next;
        last_reg <= last_next;
    end

endmodule

// File: rtl/core/ghbpf_ram.sv
// ----------------------------------------------------------------------------
// ghbpf_ram
// Simple dual-port RAM: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ghbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/ghbpf_checker.sv
// ----------------------------------------------------------------------------
// ghbpf_checker
// Port-level checks on the history buffer prefetcher, bound to the top level.
// ----------------------------------------------------------------------------
module ghbpf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       was_hit,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ghbpf_pkg::PF_W-1:0] prefetch_block,
    input logic                       last_of_run
);

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prefetch_block)
            && $stable(last_of_run))
    else $error("stalled result item changed");

    // Results are only shown while no input item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input taken while a result is pending");

    // The first prefetch of a miss is always followed by the final one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
    else $error("first prefetch not followed by the final one");

    // A hit leaves the block ready in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && was_hit |=> in_ready)
    else $error("hit item did not return to ready");

    // A miss always holds the block at least for the index update.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !was_hit |=> !in_ready && !out_valid)
    else $error("miss item finished too early");

endmodule

bind ghb_pc_stride_prefetcher ghbpf_checker u_ghbpf_checker (.*);
